// File: rtl/es2c_pkg.sv
// Shared widths and register map for the epoch-seconds-to-calendar block.
package es2c_pkg;

  localparam int unsigned SEC_W     = 39;
  localparam int unsigned OFFSET_W  = 17;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  localparam int unsigned YEAR_W    = 14;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned DAY_W     = 5;
  localparam int unsigned HOUR_W    = 5;
  localparam int unsigned MINUTE_W  = 6;
  localparam int unsigned SECOND_W  = 6;
  localparam int unsigned WEEKDAY_W = 3;
  localparam int unsigned DOY_W     = 9;

  // Register index as seen in paddr above the byte offset
  localparam logic [PADDR_W-3:0] REG_LOCAL_OFFSET = 1'b0;

endpackage

// File: rtl/es2c_in_if.sv
// Request channel carrying one timestamp into the converter.
interface es2c_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [es2c_pkg::SEC_W-1:0]  seconds_since_epoch;
  logic                               use_local;

  modport source (output valid, seconds_since_epoch, use_local, input ready);
  modport sink   (input valid, seconds_since_epoch, use_local, output ready);
endinterface

// File: rtl/es2c_out_if.sv
// Request channel carrying one calendar result out of the converter.
interface es2c_out_if;
  logic                                valid;
  logic                                ready;
  logic [es2c_pkg::YEAR_W-1:0]         year;
  logic [es2c_pkg::MONTH_W-1:0]        month;
  logic [es2c_pkg::DAY_W-1:0]          day;
  logic [es2c_pkg::HOUR_W-1:0]         hour;
  logic [es2c_pkg::MINUTE_W-1:0]       minute;
  logic [es2c_pkg::SECOND_W-1:0]       second;
  logic [es2c_pkg::WEEKDAY_W-1:0]      weekday;
  logic [es2c_pkg::DOY_W-1:0]          day_of_year;
  logic                                out_of_range;

  modport source (output valid, year, month, day, hour, minute, second, weekday,
                  day_of_year, out_of_range, input ready);
  modport sink   (input valid, year, month, day, hour, minute, second, weekday,
                  day_of_year, out_of_range, output ready);
endinterface

// File: rtl/es2c_apb.sv
// APB register file holding the local time zone offset.
module es2c_apb (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [es2c_pkg::PADDR_W-1:0]         paddr,
  input  logic [es2c_pkg::PDATA_W-1:0]         pwdata,
  output logic [es2c_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready,
  output logic signed [es2c_pkg::OFFSET_W-1:0] offset_o
);

  logic                                 reg_sel;
  logic                                 wr_en;
  logic signed [es2c_pkg::OFFSET_W-1:0] offset_q;

  assign reg_sel = (paddr[es2c_pkg::PADDR_W-1:2] == es2c_pkg::REG_LOCAL_OFFSET);
  assign wr_en   = psel & penable & pwrite & reg_sel;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (wr_en) begin
      offset_q <= pwdata[es2c_pkg::OFFSET_W-1:0];
    end
  end

  // Read back sign-extended
  assign prdata = reg_sel
    ? {{(es2c_pkg::PDATA_W - es2c_pkg::OFFSET_W){offset_q[es2c_pkg::OFFSET_W-1]}}, offset_q}
    : '0;

  assign offset_o = offset_q;

endmodule

// File: rtl/epoch_seconds_to_calendar.sv
// Eleven register stages, each with a valid bit; the last holds the result at
// out_req_o. Throughput: one request per cycle while out_req_o is ready. A
// stage loads whenever it or any stage after it holds a bubble, so a stalled
// output still lets input flow until every stage is full.
// Reset clears all valid bits and sets the local offset register to 0.
module epoch_seconds_to_calendar (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [es2c_pkg::PADDR_W-1:0] paddr,
  input  logic [es2c_pkg::PDATA_W-1:0] pwdata,
  output logic [es2c_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  es2c_in_if.sink                      in_req_i,
  es2c_out_if.source                   out_req_o
);

  localparam int unsigned NST = 11;

  // Seconds are biased so that 0001-01-01 00:00:00 is zero; the bias is a whole
  // number of days, so the day split below is a plain unsigned division.
  localparam logic signed [39:0] T_BIAS  = 40'sd62135596800;
  localparam logic [38:0]        T_MAX   = 39'd315537897599;

  // 86400 = 128 * 675: shift, then divide by 675 through a floor reciprocal.
  localparam logic [31:0] DAY_RECIP = 32'd3257812230;   // floor(2^41 / 675)
  localparam logic [31:0] DIV_675   = 32'd675;

  // days since 0001-01-01 plus this gives a + 32044 style value of the inverse JD step
  localparam logic [22:0] A_BIAS    = 23'd1753470;
  localparam logic [32:0] B_RECIP   = 33'd229;          // floor(2^25 / 146097)
  localparam logic [24:0] DIV_B     = 25'd146097;
  localparam logic [41:0] W_RECIP   = 42'd599186;       // floor(2^22 / 7)
  localparam logic [21:0] DIV_W     = 22'd7;
  localparam logic [22:0] H_RECIP   = 23'd36;           // floor(2^17 / 3600)
  localparam logic [16:0] DIV_H     = 17'd3600;
  localparam logic [25:0] D_RECIP   = 26'd179;          // floor(2^18 / 1461)
  localparam logic [17:0] DIV_D     = 18'd1461;
  localparam logic [18:0] M_RECIP   = 19'd68;           // floor(2^12 / 60)
  localparam logic [11:0] DIV_MIN   = 12'd60;
  localparam logic [14:0] MO_RECIP  = 15'd13;           // floor(2^11 / 153)
  localparam logic [10:0] DIV_MO    = 11'd153;

  // ------------------------------------------------------------------
  // Configuration
  // ------------------------------------------------------------------
  logic signed [es2c_pkg::OFFSET_W-1:0] offset;

  es2c_apb u_apb (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .offset_o (offset)
  );

  // ------------------------------------------------------------------
  // Valid bits and flow control
  // ------------------------------------------------------------------
  logic [NST:1] v_q;
  logic [NST:1] adv;

  // A stage may load when the output drains or a bubble sits at or after it.
  for (genvar k = 1; k <= NST; k++) begin : g_adv
    assign adv[k] = out_req_o.ready | ~(&v_q[NST:k]);
  end

  assign in_req_i.ready = adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[1]) begin
        v_q[1] <= in_req_i.valid;
      end
      for (int k = 2; k <= NST; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: apply offset, bias, range check
  // ------------------------------------------------------------------
  logic signed [es2c_pkg::OFFSET_W-1:0] s1_off;
  logic signed [39:0]                   s1_t_d;
  logic                                 s1_oor_d;
  logic [38:0]                          s1_t_q;
  logic                                 s1_oor_q;

  assign s1_off   = in_req_i.use_local ? offset : '0;
  assign s1_t_d   = 40'(in_req_i.seconds_since_epoch) + 40'(s1_off) + T_BIAS;
  assign s1_oor_d = s1_t_d[39] | (s1_t_d[38:0] > T_MAX);

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_t_q   <= s1_t_d[38:0];
      s1_oor_q <= s1_oor_d;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: day quotient estimate
  // ------------------------------------------------------------------
  logic [63:0] s2_prod;
  logic [21:0] s2_qd_q;
  logic [31:0] s2_u_q;
  logic [6:0]  s2_lo_q;
  logic        s2_oor_q;

  assign s2_prod = 64'(s1_t_q[38:7]) * 64'(DAY_RECIP);

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s2_qd_q  <= s2_prod[62:41];
      s2_u_q   <= s1_t_q[38:7];
      s2_lo_q  <= s1_t_q[6:0];
      s2_oor_q <= s1_oor_q;
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: day remainder against the estimate
  // ------------------------------------------------------------------
  logic [31:0] s3_r_d;
  logic [21:0] s3_qd_q;
  logic [10:0] s3_r_q;
  logic [6:0]  s3_lo_q;
  logic        s3_oor_q;

  assign s3_r_d = s2_u_q - 32'(s2_qd_q) * DIV_675;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s3_qd_q  <= s2_qd_q;
      s3_r_q   <= s3_r_d[10:0];
      s3_lo_q  <= s2_lo_q;
      s3_oor_q <= s2_oor_q;
    end
  end

  // ------------------------------------------------------------------
  // Stage 4: correct the estimate, form day count and second of day
  // ------------------------------------------------------------------
  logic        s4_ge;
  logic [10:0] s4_rr;
  logic [21:0] s4_days_q;
  logic [16:0] s4_sod_q;
  logic        s4_oor_q;

  assign s4_ge = (s3_r_q >= DIV_675[10:0]);
  assign s4_rr = s4_ge ? (s3_r_q - DIV_675[10:0]) : s3_r_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      s4_days_q <= s3_qd_q + 22'(s4_ge);
      s4_sod_q  <= {s4_rr[9:0], s3_lo_q};
      s4_oor_q  <= s3_oor_q;
    end
  end

  // ------------------------------------------------------------------
  // Stage 5: estimates for the 400-year cycle, weekday and hour
  // ------------------------------------------------------------------
  logic [22:0] s5_a;
  logic [24:0] s5_xb_d;
  logic [32:0] s5_pb;
  logic [21:0] s5_xw_d;
  logic [41:0] s5_pw;
  logic [22:0] s5_ph;
  logic [24:0] s5_xb_q;
  logic [7:0]  s5_qb_q;
  logic [21:0] s5_xw_q;
  logic [19:0] s5_qw_q;
  logic [16:0] s5_sod_q;
  logic [5:0]  s5_qh_q;
  logic        s5_oor_q;

  assign s5_a    = 23'(s4_days_q) + A_BIAS;
  assign s5_xb_d = {s5_a, 2'b11};                 // 4a + 3
  assign s5_pb   = 33'(s5_xb_d) * B_RECIP;
  assign s5_xw_d = s4_days_q + 22'd1;             // 0001-01-01 is a Monday
  assign s5_pw   = 42'(s5_xw_d) * W_RECIP;
  assign s5_ph   = 23'(s4_sod_q) * H_RECIP;

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      s5_xb_q  <= s5_xb_d;
      s5_qb_q  <= s5_pb[32:25];
      s5_xw_q  <= s5_xw_d;
      s5_qw_q  <= s5_pw[41:22];
      s5_sod_q <= s4_sod_q;
      s5_qh_q  <= s5_ph[22:17];
      s5_oor_q <= s4_oor_q;
    end
  end

  // ------------------------------------------------------------------
  // Stage 6: correct century cycle, weekday and hour
  // ------------------------------------------------------------------
  logic [24:0] s6_rb_full;
  logic [18:0] s6_rb0;
  logic        s6_geb;
  logic [18:0] s6_rb;
  logic [21:0] s6_rw_full;
  logic [3:0]  s6_rw0;
  logic        s6_gew;
  logic [3:0]  s6_rw;
  logic [16:0] s6_rh_full;
  logic [12:0] s6_rh0;
  logic        s6_geh;
  logic [12:0] s6_rh;
  logic [7:0]  s6_b_q;
  logic [17:0] s6_xd_q;
  logic [2:0]  s6_w_q;
  logic [4:0]  s6_hour_q;
  logic [11:0] s6_rh_q;
  logic        s6_oor_q;

  assign s6_rb_full = s5_xb_q - 25'(s5_qb_q) * DIV_B;
  assign s6_rb0     = s6_rb_full[18:0];
  assign s6_geb     = (s6_rb0 >= DIV_B[18:0]);
  assign s6_rb      = s6_geb ? (s6_rb0 - DIV_B[18:0]) : s6_rb0;

  assign s6_rw_full = s5_xw_q - 22'(s5_qw_q) * DIV_W;
  assign s6_rw0     = s6_rw_full[3:0];
  assign s6_gew     = (s6_rw0 >= DIV_W[3:0]);
  assign s6_rw      = s6_gew ? (s6_rw0 - DIV_W[3:0]) : s6_rw0;

  assign s6_rh_full = s5_sod_q - 17'(s5_qh_q) * DIV_H;
  assign s6_rh0     = s6_rh_full[12:0];
  assign s6_geh     = (s6_rh0 >= DIV_H[12:0]);
  assign s6_rh      = s6_geh ? (s6_rh0 - DIV_H[12:0]) : s6_rh0;

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      s6_b_q    <= s5_qb_q + 8'(s6_geb);
      s6_xd_q   <= {s6_rb[17:2], 2'b11};          // 4c + 3 with c = r / 4
      s6_w_q    <= s6_rw[2:0];
      s6_hour_q <= 5'(s5_qh_q + 6'(s6_geh));
      s6_rh_q   <= s6_rh[11:0];
      s6_oor_q  <= s5_oor_q;
    end
  end

  // ------------------------------------------------------------------
  // Stage 7: estimates for the 4-year cycle and minute
  // ------------------------------------------------------------------
  logic [25:0] s7_pd;
  logic [18:0] s7_pm;
  logic [7:0]  s7_b_q;
  logic [17:0] s7_xd_q;
  logic [7:0]  s7_qd_q;
  logic [2:0]  s7_w_q;
  logic [4:0]  s7_hour_q;
  logic [11:0] s7_rh_q;
  logic [6:0]  s7_qmin_q;
  logic        s7_oor_q;

  assign s7_pd = 26'(s6_xd_q) * D_RECIP;
  assign s7_pm = 19'(s6_rh_q) * M_RECIP;

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      s7_b_q    <= s6_b_q;
      s7_xd_q   <= s6_xd_q;
      s7_qd_q   <= s7_pd[25:18];
      s7_w_q    <= s6_w_q;
      s7_hour_q <= s6_hour_q;
      s7_rh_q   <= s6_rh_q;
      s7_qmin_q <= s7_pm[18:12];
      s7_oor_q  <= s6_oor_q;
    end
  end

  // ------------------------------------------------------------------
  // Stage 8: correct 4-year cycle, minute and second
  // ------------------------------------------------------------------
  logic [17:0] s8_rd_full;
  logic [11:0] s8_rd0;
  logic        s8_ged;
  logic [11:0] s8_rd;
  logic [11:0] s8_rs_full;
  logic [6:0]  s8_rs0;
  logic        s8_gem;
  logic [6:0]  s8_rs;
  logic [7:0]  s8_b_q;
  logic [6:0]  s8_d_q;
  logic [8:0]  s8_e_q;
  logic [2:0]  s8_w_q;
  logic [4:0]  s8_hour_q;
  logic [5:0]  s8_min_q;
  logic [5:0]  s8_sec_q;
  logic        s8_oor_q;

  assign s8_rd_full = s7_xd_q - 18'(s7_qd_q) * DIV_D;
  assign s8_rd0     = s8_rd_full[11:0];
  assign s8_ged     = (s8_rd0 >= DIV_D[11:0]);
  assign s8_rd      = s8_ged ? (s8_rd0 - DIV_D[11:0]) : s8_rd0;

  assign s8_rs_full = s7_rh_q - 12'(s7_qmin_q) * DIV_MIN;
  assign s8_rs0     = s8_rs_full[6:0];
  assign s8_gem     = (s8_rs0 >= DIV_MIN[6:0]);
  assign s8_rs      = s8_gem ? (s8_rs0 - DIV_MIN[6:0]) : s8_rs0;

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      s8_b_q    <= s7_b_q;
      s8_d_q    <= 7'(s7_qd_q + 8'(s8_ged));
      s8_e_q    <= s8_rd[10:2];                   // days since March 1
      s8_w_q    <= s7_w_q;
      s8_hour_q <= s7_hour_q;
      s8_min_q  <= 6'(s7_qmin_q + 7'(s8_gem));
      s8_sec_q  <= s8_rs[5:0];
      s8_oor_q  <= s7_oor_q;
    end
  end

  // ------------------------------------------------------------------
  // Stage 9: month estimate from the March-based day
  // ------------------------------------------------------------------
  logic [10:0] s9_xm_d;
  logic [14:0] s9_pm;
  logic [10:0] s9_xm_q;
  logic [3:0]  s9_qm_q;
  logic [7:0]  s9_b_q;
  logic [6:0]  s9_d_q;
  logic [8:0]  s9_e_q;
  logic [2:0]  s9_w_q;
  logic [4:0]  s9_hour_q;
  logic [5:0]  s9_min_q;
  logic [5:0]  s9_sec_q;
  logic        s9_oor_q;

  assign s9_xm_d = 11'(s8_e_q) * 11'd5 + 11'd2;
  assign s9_pm   = 15'(s9_xm_d) * MO_RECIP;

  always_ff @(posedge clk_i) begin
    if (adv[9]) begin
      s9_xm_q   <= s9_xm_d;
      s9_qm_q   <= s9_pm[14:11];
      s9_b_q    <= s8_b_q;
      s9_d_q    <= s8_d_q;
      s9_e_q    <= s8_e_q;
      s9_w_q    <= s8_w_q;
      s9_hour_q <= s8_hour_q;
      s9_min_q  <= s8_min_q;
      s9_sec_q  <= s8_sec_q;
      s9_oor_q  <= s8_oor_q;
    end
  end

  // ------------------------------------------------------------------
  // Stage 10: correct month index, keep remainder for the day of month
  // ------------------------------------------------------------------
  logic [10:0] s10_rm_full;
  logic [8:0]  s10_rm0;
  logic        s10_gem;
  logic [8:0]  s10_rm;
  logic [3:0]  s10_m_q;
  logic [7:0]  s10_rm_q;
  logic [7:0]  s10_b_q;
  logic [6:0]  s10_d_q;
  logic [8:0]  s10_e_q;
  logic [2:0]  s10_w_q;
  logic [4:0]  s10_hour_q;
  logic [5:0]  s10_min_q;
  logic [5:0]  s10_sec_q;
  logic        s10_oor_q;

  assign s10_rm_full = s9_xm_q - 11'(s9_qm_q) * DIV_MO;
  assign s10_rm0     = s10_rm_full[8:0];
  assign s10_gem     = (s10_rm0 >= DIV_MO[8:0]);
  assign s10_rm      = s10_gem ? (s10_rm0 - DIV_MO[8:0]) : s10_rm0;

  always_ff @(posedge clk_i) begin
    if (adv[10]) begin
      s10_m_q    <= s9_qm_q + 4'(s10_gem);
      s10_rm_q   <= s10_rm[7:0];
      s10_b_q    <= s9_b_q;
      s10_d_q    <= s9_d_q;
      s10_e_q    <= s9_e_q;
      s10_w_q    <= s9_w_q;
      s10_hour_q <= s9_hour_q;
      s10_min_q  <= s9_min_q;
      s10_sec_q  <= s9_sec_q;
      s10_oor_q  <= s9_oor_q;
    end
  end

  // ------------------------------------------------------------------
  // Stage 11: assemble the date, output register
  // ------------------------------------------------------------------
  logic [15:0] s11_pday;
  logic        s11_jan_feb;
  logic        s11_leap;
  logic [15:0] s11_year16;
  logic [es2c_pkg::YEAR_W-1:0]    s11_year_d;
  logic [es2c_pkg::MONTH_W-1:0]   s11_month_d;
  logic [es2c_pkg::DAY_W-1:0]     s11_day_d;
  logic [es2c_pkg::DOY_W-1:0]     s11_doy_d;
  logic [es2c_pkg::YEAR_W-1:0]    s11_year_q;
  logic [es2c_pkg::MONTH_W-1:0]   s11_month_q;
  logic [es2c_pkg::DAY_W-1:0]     s11_day_q;
  logic [es2c_pkg::HOUR_W-1:0]    s11_hour_q;
  logic [es2c_pkg::MINUTE_W-1:0]  s11_min_q;
  logic [es2c_pkg::SECOND_W-1:0]  s11_sec_q;
  logic [es2c_pkg::WEEKDAY_W-1:0] s11_w_q;
  logic [es2c_pkg::DOY_W-1:0]     s11_doy_q;
  logic                           s11_oor_q;

  // Remainder / 5 through 205 / 1024, exact for the small remainder range
  assign s11_pday    = 16'(s10_rm_q) * 16'd205;
  assign s11_day_d   = s11_pday[14:10] + 5'd1;

  // January and February belong to the next calendar year of the March-based year
  assign s11_jan_feb = (s10_m_q >= 4'd10);
  assign s11_month_d = s11_jan_feb ? (s10_m_q - 4'd9) : (s10_m_q + 4'd3);
  assign s11_year16  = 16'(s10_b_q) * 16'd100 + 16'(s10_d_q) + 16'(s11_jan_feb)
                     - 16'd4800;
  assign s11_year_d  = s11_year16[es2c_pkg::YEAR_W-1:0];

  // Leap test of the March-based year: divisible by 4 via d, by 100 when d is
  // zero, and then by 400 via the century count b.
  assign s11_leap    = (s10_d_q[1:0] == 2'b00) &&
                       ((s10_d_q != 7'd0) || (s10_b_q[1:0] == 2'b00));
  assign s11_doy_d   = s11_jan_feb ? (s10_e_q - 9'd306)
                                   : (s10_e_q + 9'd59 + 9'(s11_leap));

  // Zero every calendar field of a result that falls outside years 1 to 9999
  always_ff @(posedge clk_i) begin
    if (adv[11]) begin
      s11_oor_q   <= s10_oor_q;
      s11_year_q  <= s10_oor_q ? '0 : s11_year_d;
      s11_month_q <= s10_oor_q ? '0 : s11_month_d;
      s11_day_q   <= s10_oor_q ? '0 : s11_day_d;
      s11_hour_q  <= s10_oor_q ? '0 : s10_hour_q;
      s11_min_q   <= s10_oor_q ? '0 : s10_min_q;
      s11_sec_q   <= s10_oor_q ? '0 : s10_sec_q;
      s11_w_q     <= s10_oor_q ? '0 : s10_w_q;
      s11_doy_q   <= s10_oor_q ? '0 : s11_doy_d;
    end
  end

  assign out_req_o.valid        = v_q[NST];
  assign out_req_o.year         = s11_year_q;
  assign out_req_o.month        = s11_month_q;
  assign out_req_o.day          = s11_day_q;
  assign out_req_o.hour         = s11_hour_q;
  assign out_req_o.minute       = s11_min_q;
  assign out_req_o.second       = s11_sec_q;
  assign out_req_o.weekday      = s11_w_q;
  assign out_req_o.day_of_year  = s11_doy_q;
  assign out_req_o.out_of_range = s11_oor_q;

endmodule
